FILE: hw/rtl/ssrch_pkg.sv
// ssrch_pkg: shared types and codes for the streaming substring search block
// no dependencies; imported by every module of the block
package ssrch_pkg;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int OUT_IDX_W = 32;

    // item kinds carried on the mode field
    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // terminator byte for both pattern and text
    localparam logic [BYTE_W-1:0] TERM_BYTE = '0;

    // result status codes
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_t;

    // result word produced by the search stage
    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic [OUT_IDX_W-1:0] index;
    } result_t;

endpackage

FILE: hw/rtl/ssrch_pattern.sv
// ssrch_pattern: pattern byte store, fill count, closed length and overflow flag
// depends on ssrch_pkg
module ssrch_pattern #(
    parameter int MAX_QUERY = 16,
    parameter int CNT_W     = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         mode,
    input  logic [ssrch_pkg::BYTE_W-1:0] data_byte,
    output logic [ssrch_pkg::BYTE_W-1:0] store [MAX_QUERY],
    output logic [CNT_W-1:0]             length,
    output logic                         overflow
);
    import ssrch_pkg::*;

    localparam int IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_QUERY);

    logic [BYTE_W-1:0] store_reg [MAX_QUERY];
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  length_reg, length_next;
    logic              overflow_reg, overflow_next;
    logic              write_en;

    // pattern load control
    always_comb
    begin
        fill_next     = fill_reg;
        length_next   = length_reg;
        overflow_next = overflow_reg;
        write_en      = 1'b0;
        if (en && mode == MODE_PATTERN)
        begin
            if (fill_reg == '0)
            begin
                overflow_next = 1'b0;
            end
            if (data_byte == TERM_BYTE)
            begin
                length_next = fill_reg;
                fill_next   = '0;
            end
            else if (fill_reg < MAX_CNT)
            begin
                write_en  = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            length_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
        end
    end

    // byte store, no reset
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            store_reg[fill_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    assign store    = store_reg;
    assign length   = length_reg;
    assign overflow = overflow_reg;

endmodule

FILE: hw/rtl/ssrch_text.sv
// ssrch_text: text side of the search, a row of partial-match cells, the text
// position counter and the match-seen flag; depends on ssrch_pkg
module ssrch_text #(
    parameter int MAX_QUERY  = 16,
    parameter int INDEX_BITS = 32,
    parameter int CNT_W      = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         en,
    input  logic                         mode,
    input  logic [ssrch_pkg::BYTE_W-1:0] data_byte,
    input  logic [ssrch_pkg::BYTE_W-1:0] store [MAX_QUERY],
    input  logic [CNT_W-1:0]             length,
    input  logic                         overflow,
    output ssrch_pkg::result_t           res
);
    import ssrch_pkg::*;

    localparam int IDX_W  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int WIDE_W = (INDEX_BITS > OUT_IDX_W) ? INDEX_BITS : OUT_IDX_W;

    // cell j set: the text so far ends in pattern bytes 0..j
    logic [MAX_QUERY-1:0]  part_reg, part_next, part_step;
    logic [INDEX_BITS-1:0] pos_reg, pos_next, pos_inc;
    logic                  seen_reg, seen_next;
    logic [CNT_W-1:0]      len_m1;
    logic                  hit;
    logic [WIDE_W-1:0]     idx_wide;
    logic [OUT_IDX_W-1:0]  idx_out;

    // one compare per cell against the new byte
    always_comb
    begin
        for (int j = 0; j < MAX_QUERY; j++)
        begin
            if (j == 0)
            begin
                part_step[j] = (store[j] == data_byte);
            end
            else
            begin
                part_step[j] = part_reg[j-1] && (store[j] == data_byte);
            end
        end
    end

    // saturating position and match check
    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign len_m1  = length - 1'b1;
    assign hit     = !overflow && (length != '0) && part_step[len_m1[IDX_W-1:0]];
    assign idx_wide = WIDE_W'(pos_inc) - WIDE_W'(length);

    // clamp the start offset to the output width
    generate
        if (WIDE_W > OUT_IDX_W)
        begin : g_clamp
            assign idx_out = (idx_wide[WIDE_W-1:OUT_IDX_W] != '0) ? '1
                                                                  : idx_wide[OUT_IDX_W-1:0];
        end
        else
        begin : g_plain
            assign idx_out = idx_wide[OUT_IDX_W-1:0];
        end
    endgenerate

    // result and next state for the word in the stage
    always_comb
    begin
        part_next  = part_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        res.valid  = 1'b0;
        res.status = ST_FOUND;
        res.index  = '0;
        if (mode == MODE_PATTERN || data_byte == TERM_BYTE)
        begin
            part_next = '0;
            pos_next  = '0;
            seen_next = 1'b0;
            if (mode == MODE_TEXT && !seen_reg)
            begin
                res.valid  = item_valid;
                res.status = overflow ? ST_TOO_LONG : ST_NOT_FOUND;
            end
        end
        else if (!seen_reg)
        begin
            part_next = part_step;
            pos_next  = pos_inc;
            if (hit)
            begin
                seen_next  = 1'b1;
                res.valid  = item_valid;
                res.status = ST_FOUND;
                res.index  = idx_out;
            end
        end
    end

    // text state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= '0;
            pos_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else if (en)
        begin
            part_reg <= part_next;
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
        end
    end

endmodule

FILE: hw/rtl/stream_substring_search.sv
// stream_substring_search: top level with input stage, pattern and text units,
// and the result register; depends on ssrch_pkg, ssrch_pattern, ssrch_text
//
//   channel  signals                          direction  contents
//   in       in_valid, in_ready               sink       mode, data_byte
//   out      out_valid, out_ready             source     status, match_index
//
// One word per cycle in and out. A word is registered at acceptance and handled
// from the input stage; its result (if any) is loaded into the output register
// when the stage advances, and out_valid rises as it is loaded.
// The stage stalls only when its word makes a result and the output register
// is still held by out_ready low; words that make no result never stall.
// Reset clears pattern length, fill count, overflow flag and text state.
module stream_substring_search #(
    parameter int MAX_QUERY  = 16,
    parameter int INDEX_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [ssrch_pkg::BYTE_W-1:0] data_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [ssrch_pkg::OUT_IDX_W-1:0] match_index
);
    import ssrch_pkg::*;

    localparam int CNT_W = $clog2(MAX_QUERY + 1);

    logic                  stage_valid_reg, stage_valid_next;
    logic                  mode_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  advance;
    logic                  in_take;
    logic [BYTE_W-1:0]     store [MAX_QUERY];
    logic [CNT_W-1:0]      length;
    logic                  overflow;
    result_t               res;
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg;
    logic [OUT_IDX_W-1:0]  index_reg;

    // stage moves unless its result would overwrite a waiting one
    assign advance  = stage_valid_reg && (!res.valid || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= mode;
            byte_reg <= data_byte;
        end
    end

    // pattern unit
    ssrch_pattern #(
        .MAX_QUERY (MAX_QUERY),
        .CNT_W     (CNT_W)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .mode      (mode_reg),
        .data_byte (byte_reg),
        .store     (store),
        .length    (length),
        .overflow  (overflow)
    );

    // text unit
    ssrch_text #(
        .MAX_QUERY  (MAX_QUERY),
        .INDEX_BITS (INDEX_BITS),
        .CNT_W      (CNT_W)
    ) u_text (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stage_valid_reg),
        .en         (advance),
        .mode       (mode_reg),
        .data_byte  (byte_reg),
        .store      (store),
        .length     (length),
        .overflow   (overflow),
        .res        (res)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            status_reg <= res.status;
            index_reg  <= res.index;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign match_index = index_reg;

endmodule

FILE: tb/ssrch_checker.sv
// ssrch_checker: watches both channels of stream_substring_search, predicts each result
// and compares it with what the block returns; depends on ssrch_pkg
module ssrch_checker #(
    parameter int MAX_QUERY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            mode,
    input  logic [ssrch_pkg::BYTE_W-1:0]    data_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      status,
    input  logic [ssrch_pkg::OUT_IDX_W-1:0] match_index,
    output int                              fail_count,
    output int                              outstanding,
    output int                              live_words,
    output int                              found_count,
    output int                              missed_count,
    output int                              too_long_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssrch_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [OUT_IDX_W-1:0] index;
    } search_result_t;

    // predicted search state
    logic [BYTE_W-1:0]    pattern_bytes [MAX_QUERY] = '{default: '0};
    int                   pattern_len        = 0;
    int                   fill_count         = 0;
    logic                 pattern_overflowed = 1'b0;
    logic [BYTE_W-1:0]    recent_text [MAX_QUERY] = '{default: '0};
    logic [OUT_IDX_W-1:0] text_pos           = '0;
    logic                 hit_reported       = 1'b0;

    search_result_t       pending_results [$];
    int                   words_seen = 0;
    int                   failures   = 0;

    initial
    begin
        fail_count     = 0;
        outstanding    = 0;
        live_words     = 0;
        found_count    = 0;
        missed_count   = 0;
        too_long_count = 0;
    end

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    task automatic clear_text_state();
        recent_text  = '{default: '0};
        text_pos     = '0;
        hit_reported = 1'b0;
    endtask

    // work out the result (if any) of one accepted word
    task automatic predict_word(input logic kind, input logic [BYTE_W-1:0] b);
        logic           hit;
        search_result_t res;
        words_seen++;
        if (kind == MODE_PATTERN)
        begin
            clear_text_state();
            if (fill_count == 0)
                pattern_overflowed = 1'b0;
            if (b == TERM_BYTE)
            begin
                pattern_len = fill_count;
                fill_count  = 0;
            end
            else if (fill_count < MAX_QUERY)
            begin
                pattern_bytes[fill_count] = b;
                fill_count++;
            end
            else
                pattern_overflowed = 1'b1;
        end
        else if (b == TERM_BYTE)
        begin
            // text end reports only when no match was already given
            if (!hit_reported)
            begin
                res.status = pattern_overflowed ? ST_TOO_LONG : ST_NOT_FOUND;
                res.index  = '0;
                pending_results.push_back(res);
            end
            clear_text_state();
        end
        else if (!hit_reported)
        begin
            for (int i = MAX_QUERY - 1; i > 0; i--)
                recent_text[i] = recent_text[i-1];
            recent_text[0] = b;
            if (text_pos != '1)
                text_pos++;
            // newest byte sits at window slot zero, pattern start is the oldest
            hit = !pattern_overflowed && pattern_len != 0 && text_pos >= pattern_len;
            for (int k = 0; k < MAX_QUERY; k++)
                if (hit && k < pattern_len && pattern_bytes[k] != recent_text[pattern_len-1-k])
                    hit = 1'b0;
            if (hit)
            begin
                hit_reported = 1'b1;
                res.status   = ST_FOUND;
                res.index    = text_pos - OUT_IDX_W'(pattern_len);
                pending_results.push_back(res);
            end
        end
    endtask

    // compare results, then predict from the accepted word
    always @(posedge clk)
    begin
        search_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    note_failure($sformatf("unexpected result: status %0d index %0d",
                                           status, match_index));
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || match_index !== want.index)
                        note_failure($sformatf(
                            "mismatch: expected status %0d index %0d, got status %0d index %0d",
                            want.status, want.index, status, match_index));
                    else if (want.status == ST_FOUND)
                        found_count <= found_count + 1;
                    else if (want.status == ST_NOT_FOUND)
                        missed_count <= missed_count + 1;
                    else
                        too_long_count <= too_long_count + 1;
                end
            end
            if (in_valid && in_ready)
                predict_word(mode, data_byte);
        end
        fail_count  <= failures;
        outstanding <= pending_results.size();
        live_words  <= words_seen;
    end

endmodule

FILE: tb/testbench.sv
// testbench: drives pattern and text words into stream_substring_search and gives the verdict
// depends on ssrch_pkg, stream_substring_search and ssrch_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssrch_pkg::*;

    localparam int MAX_QUERY  = 16;
    localparam int INDEX_BITS = 32;
    localparam int WORD_GOAL  = 480;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 mode      = MODE_PATTERN;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [1:0]           status;
    logic [OUT_IDX_W-1:0] match_index;
    bit                   steady    = 1'b0;

    int fail_count, outstanding, live_words, found_count, missed_count, too_long_count;

    always #1 clk = ~clk;

    stream_substring_search #(
        .MAX_QUERY  (MAX_QUERY),
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .match_index (match_index)
    );

    ssrch_checker #(
        .MAX_QUERY (MAX_QUERY)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .match_index    (match_index),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .live_words     (live_words),
        .found_count    (found_count),
        .missed_count   (missed_count),
        .too_long_count (too_long_count)
    );

    // result side stalls at random outside the steady stretch
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 33);

    // present one word, with random idle cycles ahead of it
    task automatic send_word(input logic kind, input logic [BYTE_W-1:0] b);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        mode      <= kind;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input int base, input int span);
        return BYTE_W'(base + $urandom_range(0, span - 1));
    endfunction

    // hard stop
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [BYTE_W-1:0] pat [20];
        int plen, tlen, at, n_text, base, span, shape, seq, pick;
        logic broken;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty pattern out of reset: text end says not found
        send_word(MODE_TEXT, 8'h41);
        send_word(MODE_TEXT, TERM_BYTE);
        // pattern ff 01, match at offset 1, later bytes and the end are ignored
        send_word(MODE_PATTERN, 8'hFF);
        send_word(MODE_PATTERN, 8'h01);
        send_word(MODE_PATTERN, TERM_BYTE);
        send_word(MODE_TEXT, 8'h01);
        send_word(MODE_TEXT, 8'hFF);
        send_word(MODE_TEXT, 8'h01);
        send_word(MODE_TEXT, 8'h7F);
        send_word(MODE_TEXT, TERM_BYTE);
        // text while a new pattern is half loaded uses the old length
        send_word(MODE_PATTERN, 8'h01);
        send_word(MODE_TEXT, 8'h01);
        send_word(MODE_TEXT, 8'h01);
        send_word(MODE_TEXT, TERM_BYTE);
        send_word(MODE_PATTERN, TERM_BYTE);
        // explicit empty pattern never matches
        send_word(MODE_PATTERN, TERM_BYTE);
        send_word(MODE_TEXT, 8'h80);
        send_word(MODE_TEXT, TERM_BYTE);

        // hold off until the directed results are all back
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);

        // random sequences: mostly pattern then texts, some noise and broken ones
        seq = 0;
        while (live_words < WORD_GOAL)
        begin
            steady = (seq >= 12 && seq < 24);
            seq++;
            shape = $urandom_range(0, 99);
            if (shape < 10)
            begin
                repeat ($urandom_range(1, 6))
                    send_word(1'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) == 0) ? TERM_BYTE
                                                          : BYTE_W'($urandom_range(1, 255)));
            end
            else
            begin
                broken = (shape < 18);
                // small alphabets make matches common
                pick = $urandom_range(0, 3);
                span = (pick == 3) ? 255 : pick + 2;
                base = $urandom_range(1, 256 - span);
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    plen = 0;
                else if (pick < 15)
                    plen = $urandom_range(MAX_QUERY + 1, 20);
                else if (pick < 25)
                    plen = $urandom_range(5, MAX_QUERY);
                else
                    plen = $urandom_range(1, 4);
                for (int i = 0; i < plen; i++)
                begin
                    pat[i] = pick_byte(base, span);
                    send_word(MODE_PATTERN, pat[i]);
                end
                if (!broken)
                    send_word(MODE_PATTERN, TERM_BYTE);
                n_text = $urandom_range(1, 3);
                repeat (n_text)
                begin
                    tlen = $urandom_range(0, 24);
                    at = ($urandom_range(0, 1) == 1 && plen > 0) ? $urandom_range(0, tlen) : -1;
                    for (int i = 0; i < tlen; i++)
                    begin
                        if (i == at)
                            for (int k = 0; k < plen; k++)
                                send_word(MODE_TEXT, pat[k]);
                        send_word(MODE_TEXT, pick_byte(base, span));
                    end
                    if (!(broken && $urandom_range(0, 1) == 1))
                        send_word(MODE_TEXT, TERM_BYTE);
                end
            end
        end

        // drain
        steady = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("covered %0d words in %0d random sequences", live_words, seq);
        $display("results: %0d found, %0d not found, %0d too long, %0d failures",
                 found_count, missed_count, too_long_count, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
